// ===== design/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants for the day count to date converter
// Controller states, command and status bundles, calendar tables and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

    localparam int DCC_DAY_BITS_DEF = 20;

    localparam int          CYCLE_DAYS   = 146097;  // days in 400 Gregorian years
    localparam logic [12:0] CYCLE_YEARS  = 13'd400;
    localparam logic [12:0] BASE_YEAR    = 13'd2000;
    localparam logic [2:0]  BASE_WEEKDAY = 3'd5;    // 2000-01-01 is a Saturday
    localparam logic [3:0]  LAST_MONTH   = 4'd11;   // December, zero based
    localparam logic [3:0]  FEBRUARY     = 4'd1;
    localparam logic [8:0]  YEAR_IDX_LAST = 9'd399;
    localparam logic [6:0]  CENT_LAST    = 7'd99;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CYCLE,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic cyc_step;
        logic year_step;
        logic month_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cyc_ge;
        logic year_ge;
        logic month_ge;
    } t_status;

    // Days in a zero-based month.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
                4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
                FEBRUARY:                                  len = leap ? 5'd29 : 5'd28;
                default:                                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Remainder by seven of a value below 32.
    function automatic logic [2:0] mod7(input logic [4:0] v);
        logic [4:0] r;
        begin
            r = v;
            for (int k = 0; k < 4; k++) begin
                if (r >= 5'd7) begin
                    r = r - 5'd7;
                end
            end
            return r[2:0];
        end
    endfunction

    // Weekday plus an offset of 0..6, wrapped into 0..6.
    function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= 4'd7) begin
                s = s - 4'd7;
            end
            return s[2:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/dcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcc_ctrl: sequencer of the date conversion
// Steps the datapath through 400-year cycles, single years and months.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_ctrl
    import dcc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CYCLE;
                end
            end
            ST_CYCLE: begin
                if (i_status.cyc_ge) begin
                    o_cmd.cyc_step = 1'b1;
                end else begin
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (i_status.year_ge) begin
                    o_cmd.year_step = 1'b1;
                end else begin
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (i_status.month_ge) begin
                    o_cmd.month_step = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_DONE;
                end
            end
            ST_DONE: begin
                o_valid = 1'b1;
                // hold the result until the transfer
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/dcc_datapath.sv =====
// ----------------------------------------------------------------------------
// dcc_datapath: day count, year, month and weekday registers
// Subtracts one period per command and keeps the leap phase in counters.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_datapath
    import dcc_pkg::*;
#(
    parameter int DAY_BITS = DCC_DAY_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic [DAY_BITS-1:0] i_day_offset,
    input  wire t_cmd                i_cmd,
    output t_status                  o_status,
    output logic [12:0]              o_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day_of_month,
    output logic [2:0]               o_weekday
);

    localparam logic [DAY_BITS-1:0] CYC_SUB = DAY_BITS'(CYCLE_DAYS);

    logic [DAY_BITS-1:0] r_days;
    logic [12:0]         r_year;
    logic [8:0]          r_yidx;   // year within the 400-year cycle
    logic [6:0]          r_cent;   // year within the century
    logic [3:0]          r_month;  // zero based
    logic [2:0]          r_wd;

    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mlen;
    logic [31:0] days_ext;

    assign days_ext = 32'(r_days);
    assign leap     = ((r_yidx[1:0] == 2'd0) && (r_cent != 7'd0)) || (r_yidx == 9'd0);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mlen     = month_len(r_month, leap);

    assign o_status.cyc_ge   = days_ext >= 32'(CYCLE_DAYS);
    assign o_status.year_ge  = days_ext >= 32'(year_len);
    assign o_status.month_ge = (r_month < LAST_MONTH) && (days_ext >= 32'(mlen));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_days  <= i_day_offset;
            r_year  <= BASE_YEAR;
            r_yidx  <= '0;
            r_cent  <= '0;
            r_month <= '0;
            r_wd    <= BASE_WEEKDAY;
        end
        // a full cycle is a whole number of weeks: weekday stays
        if (i_cmd.cyc_step) begin
            r_days <= r_days - CYC_SUB;
            r_year <= r_year + CYCLE_YEARS;
        end
        if (i_cmd.year_step) begin
            r_days <= r_days - DAY_BITS'(year_len);
            r_year <= r_year + 13'd1;
            r_yidx <= (r_yidx == YEAR_IDX_LAST) ? 9'd0 : r_yidx + 9'd1;
            r_cent <= (r_cent == CENT_LAST) ? 7'd0 : r_cent + 7'd1;
            r_wd   <= wd_add(r_wd, leap ? 3'd2 : 3'd1);
        end
        if (i_cmd.month_step) begin
            r_days  <= r_days - DAY_BITS'(mlen);
            r_month <= r_month + 4'd1;
            r_wd    <= wd_add(r_wd, mod7(mlen));
        end
        if (i_cmd.finish) begin
            o_year         <= r_year;
            o_month        <= r_month + 4'd1;
            o_day_of_month <= r_days[4:0] + 5'd1;
            o_weekday      <= wd_add(r_wd, mod7(r_days[4:0]));
        end
    end

endmodule

`default_nettype wire

// ===== design/day_count_to_calendar_date.sv =====
// Sequence: after the input transfer the sequencer steps C whole 400-year periods
//   (at most 114 at 24 day bits), Y leftover years (at most 399) and M months
//   (at most 11), then registers the result and raises o_valid.
// Throughput: one item at a time; the sequencer steps 400-year periods, then years,
//   then months; next input taken after the result transfer.
// Reset: synchronous, active low; returns the sequencer to idle, no result pending.
// ----------------------------------------------------------------------------
// day_count_to_calendar_date: Gregorian date and weekday from a day count
// Converts days since 2000-01-01 into year, month, day of month and weekday.
// ----------------------------------------------------------------------------
`default_nettype none

module day_count_to_calendar_date
    import dcc_pkg::*;
#(
    parameter int DAY_BITS = DCC_DAY_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [DAY_BITS-1:0] i_day_offset,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [12:0]              o_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day_of_month,
    output logic [2:0]               o_weekday
);

    t_cmd    cmd;
    t_status status;

    dcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dcc_datapath #(
        .DAY_BITS (DAY_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_day_offset   (i_day_offset),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_weekday      (o_weekday)
    );

endmodule

`default_nettype wire

// ===== design/dcc_checker.sv =====
// ----------------------------------------------------------------------------
// dcc_checker: port-level checks of the date converter
// Watches handshakes and result ranges on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [12:0]         o_year,
    input wire logic [3:0]          o_month,
    input wire logic [4:0]          o_day_of_month,
    input wire logic [2:0]          o_weekday
);

    // no result pending right after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_year) && $stable(o_month)
            && $stable(o_day_of_month) && $stable(o_weekday))
        else $error("stalled result changed");

    // input transfer makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second input taken while converting");

    // one item in flight: no input taken while a result waits
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day_of_month != 5'd0)
            && (o_weekday <= 3'd6))
        else $error("result field out of range");

endmodule

bind day_count_to_calendar_date dcc_checker u_dcc_checker (.*);

`default_nettype wire
